// ===== rtl/b64d_pkg.sv =====
package b64d_pkg;

  localparam int unsigned CharWidth   = 8;
  localparam int unsigned SextetWidth = 6;
  localparam int unsigned GroupWidth  = 3 * SextetWidth;
  localparam int unsigned WordWidth   = 4 * SextetWidth;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CharWidth-1:0] CharCr      = 8'h0D;
  localparam logic [CharWidth-1:0] CharLf      = 8'h0A;
  localparam logic [CharWidth-1:0] CharPad     = 8'h3D;
  localparam logic [CharWidth-1:0] CharUpperA  = 8'h41;
  localparam logic [CharWidth-1:0] CharUpperZ  = 8'h5A;
  localparam logic [CharWidth-1:0] CharLowerA  = 8'h61;
  localparam logic [CharWidth-1:0] CharLowerZ  = 8'h7A;
  localparam logic [CharWidth-1:0] CharDigit0  = 8'h30;
  localparam logic [CharWidth-1:0] CharDigit9  = 8'h39;
  localparam logic [CharWidth-1:0] Char62Reset = 8'h2B;
  localparam logic [CharWidth-1:0] Char63Reset = 8'h2F;

  localparam logic [CharWidth-1:0] LowerOffset = 8'd26;
  localparam logic [CharWidth-1:0] DigitOffset = 8'd52;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgCharSixtyTwo   = 2'd0,
    CfgCharSixtyThree = 2'd1
  } cfg_idx_e;

  // One queue entry holds every result caused by one accepted character.
  typedef struct packed {
    logic [WordWidth-1:0] bytes;
    logic [1:0]           last_idx;
    logic                 bad;
    logic                 marker;
    logic                 last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Returns {invalid, sextet}.
  function automatic logic [SextetWidth:0] sextet_of(
    input logic [CharWidth-1:0] c,
    input logic [CharWidth-1:0] c62,
    input logic [CharWidth-1:0] c63
  );
    logic [SextetWidth:0] r;
    r = '0;
    priority if (c >= CharUpperA && c <= CharUpperZ) begin
      r = {1'b0, SextetWidth'(c - CharUpperA)};
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      r = {1'b0, SextetWidth'(c - CharLowerA + LowerOffset)};
    end else if (c >= CharDigit0 && c <= CharDigit9) begin
      r = {1'b0, SextetWidth'(c - CharDigit0 + DigitOffset)};
    end else if (c == c62) begin
      r = {1'b0, 6'd62};
    end else if (c == c63) begin
      r = {1'b0, 6'd63};
    end else begin
      r = {1'b1, 6'd0};
    end
    return r;
  endfunction

endpackage

// ===== rtl/b64d_if.sv =====
interface b64d_in_if import b64d_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] text_char;
  logic                 end_of_stream;

  modport source (output valid, output text_char, output end_of_stream, input ready);
  modport sink   (input valid, input text_char, input end_of_stream, output ready);
endinterface

interface b64d_out_if import b64d_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] data_byte;
  logic                 byte_valid;
  logic                 last_of_stream;
  logic                 bad_character;

  modport source (output valid, output data_byte, output byte_valid,
                  output last_of_stream, output bad_character, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input last_of_stream, input bad_character, output ready);
endinterface

// ===== rtl/b64d_front.sv =====
module b64d_front import b64d_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CharWidth-1:0]   cfg_data_i,
  b64d_in_if.sink                in_chan_i,
  input  q_status_t              q_status_i,
  output logic                   push_o,
  output job_t                   job_o
);

  logic [CharWidth-1:0]  char62_q, char62_d;
  logic [CharWidth-1:0]  char63_q, char63_d;
  logic [GroupWidth-1:0] group_q, group_d;
  logic [1:0]            count_q, count_d;
  logic                  accept;
  logic                  skip;
  logic [SextetWidth:0]  dec;
  logic                  has_job;
  job_t                  job;

  assign in_chan_i.ready = !q_status_i.full;
  assign accept = in_chan_i.valid && in_chan_i.ready;

  always_comb begin
    char62_d = char62_q;
    char63_d = char63_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCharSixtyTwo:   char62_d = cfg_data_i;
        CfgCharSixtyThree: char63_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    skip    = (in_chan_i.text_char == CharCr) || (in_chan_i.text_char == CharLf) ||
              (in_chan_i.text_char == CharPad);
    dec     = sextet_of(in_chan_i.text_char, char62_q, char63_q);
    group_d = group_q;
    count_d = count_q;
    has_job = 1'b0;
    job     = '0;

    if (!skip) begin
      if (dec[SextetWidth]) begin
        has_job = 1'b1;
        job.bad = 1'b1;
        group_d = '0;
        count_d = '0;
      end else if (count_q == 2'd3) begin
        has_job       = 1'b1;
        job.bytes     = {group_q, dec[SextetWidth-1:0]};
        job.last_idx  = 2'd2;
        group_d       = '0;
        count_d       = '0;
      end else begin
        group_d = {group_q[GroupWidth-SextetWidth-1:0], dec[SextetWidth-1:0]};
        count_d = count_q + 2'd1;
      end
    end

    if (in_chan_i.end_of_stream) begin
      if (!has_job) begin
        has_job = 1'b1;
        unique case (count_d)
          2'd1: job.bytes[23:16] = {group_d[5:0], 2'b00};
          2'd2: job.bytes[23:16] = group_d[11:4];
          2'd3: begin
            job.bytes[23:8] = group_d[17:2];
            job.last_idx    = 2'd1;
          end
          default: job.marker = 1'b1;
        endcase
      end
      job.last = 1'b1;
      group_d  = '0;
      count_d  = '0;
    end
  end

  assign push_o = accept && has_job;
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char62_q <= Char62Reset;
      char63_q <= Char63Reset;
      group_q  <= '0;
      count_q  <= '0;
    end else begin
      char62_q <= char62_d;
      char63_q <= char63_d;
      if (accept) begin
        group_q <= group_d;
        count_q <= count_d;
      end
    end
  end

endmodule

// ===== rtl/b64d_queue.sv =====
module b64d_queue import b64d_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output job_t      head_o,
  output q_status_t status_o
);

  localparam int unsigned AddrWidth  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountWidth = $clog2(Depth + 1);

  job_t                  mem_q [Depth];
  logic [AddrWidth-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrWidth-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CountWidth-1:0] count_q, count_d;

  assign status_o.full  = (count_q == CountWidth'(Depth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrWidth'(Depth - 1)) ? '0 : wr_ptr_q + AddrWidth'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrWidth'(Depth - 1)) ? '0 : rd_ptr_q + AddrWidth'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CountWidth'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CountWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/b64d_back.sv =====
module b64d_back import b64d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      head_i,
  input  q_status_t status_i,
  output logic      pop_o,
  b64d_out_if.source out_chan_o
);

  logic [1:0]           sub_q, sub_d;
  logic                 valid_q, valid_d;
  logic [CharWidth-1:0] byte_q, byte_d;
  logic                 byte_valid_q, byte_valid_d;
  logic                 last_q, last_d;
  logic                 bad_q, bad_d;
  logic                 load;

  assign load  = !status_i.empty && (!valid_q || out_chan_o.ready);
  assign pop_o = load && (sub_q == head_i.last_idx);

  always_comb begin
    sub_d        = sub_q;
    valid_d      = valid_q;
    byte_d       = byte_q;
    byte_valid_d = byte_valid_q;
    last_d       = last_q;
    bad_d        = bad_q;
    if (load) begin
      valid_d      = 1'b1;
      byte_valid_d = !(head_i.bad || head_i.marker);
      bad_d        = head_i.bad;
      last_d       = head_i.last && pop_o;
      sub_d        = pop_o ? 2'd0 : sub_q + 2'd1;
      unique case (sub_q)
        2'd0:    byte_d = head_i.bytes[23:16];
        2'd1:    byte_d = head_i.bytes[15:8];
        default: byte_d = head_i.bytes[7:0];
      endcase
    end else if (out_chan_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      sub_q   <= sub_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q       <= byte_d;
    byte_valid_q <= byte_valid_d;
    last_q       <= last_d;
    bad_q        <= bad_d;
  end

  assign out_chan_o.valid          = valid_q;
  assign out_chan_o.data_byte      = byte_q;
  assign out_chan_o.byte_valid     = byte_valid_q;
  assign out_chan_o.last_of_stream = last_q;
  assign out_chan_o.bad_character  = bad_q;

endmodule

// ===== rtl/base64_stream_decoder_top.sv =====
// Streaming base64 decoder that takes one text character per cycle while its
// queue has room and gives one result per cycle while its output is ready.
// CR, LF and '=' are dropped; every fourth alphabet character yields three
// bytes, a character outside the alphabet yields one result flagged as bad,
// and a character marked as end of stream flushes the partial group and marks
// the final result. The front stage decodes a character in the cycle that
// accepts it and writes all its results as one entry into a queue of
// QueueDepth entries; the back stage hands these results out one per cycle,
// while the output is ready, through an output register. Input is taken every
// cycle while the queue has room, so the sustained rate is one character per
// cycle if the output is ready and the text does not average more than one
// result per character, which the output port bounds at one result per cycle.
module base64_stream_decoder_top import b64d_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CharWidth-1:0]   cfg_data_i,
  b64d_in_if.sink                in_chan_i,
  b64d_out_if.source             out_chan_o
);

  logic      push;
  logic      pop;
  job_t      job;
  job_t      head;
  q_status_t q_status;

  b64d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_chan_i  (in_chan_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (job)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  b64d_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .status_i   (q_status),
    .pop_o      (pop),
    .out_chan_o (out_chan_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_status.full)
    else $error("Queue written while full.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_status.empty)
    else $error("Queue read while empty.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_chan_o.valid && out_chan_o.bad_character) |->
      (!out_chan_o.byte_valid && out_chan_o.data_byte == '0))
    else $error("Bad character result carries a data byte.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_chan_o.valid && !out_chan_o.byte_valid) |-> (out_chan_o.data_byte == '0))
    else $error("Result without a byte has nonzero data.");

endmodule
